// ===== hdl/lfgr_pkg.sv =====
`timescale 1ns / 1ps

package lfgr_pkg;

  localparam int GRB_W = 24;
  localparam int CHAN_W = 8;
  localparam int SEL_W = 3;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 3;

  // Input operation codes.
  localparam logic OP_PIXEL     = 1'b0;
  localparam logic OP_FRAME_END = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_COLOR_SELECT  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_ENABLE = 1'd1;

  // Palette indexes.
  localparam logic [SEL_W-1:0] PAL_RED    = 3'd0;
  localparam logic [SEL_W-1:0] PAL_GREEN  = 3'd1;
  localparam logic [SEL_W-1:0] PAL_BLUE   = 3'd2;
  localparam logic [SEL_W-1:0] PAL_YELLOW = 3'd3;
  localparam logic [SEL_W-1:0] PAL_PURPLE = 3'd4;

  typedef struct packed {
    logic             op;
    logic [GRB_W-1:0] pixel_grb;
  } in_item_t;

  typedef struct packed {
    logic [GRB_W-1:0] led_grb;
    logic             last;
  } out_item_t;

  // Request from the frame logic to the LED word sequencer.
  typedef struct packed {
    logic             go;
    logic [SEL_W-1:0] sel;
  } emit_req_t;

endpackage

// ===== hdl/lfgr_scale.sv =====
`timescale 1ns / 1ps

module lfgr_scale (
  input  logic [lfgr_pkg::CHAN_W-1:0] chan_i,
  input  logic [lfgr_pkg::CHAN_W-1:0] bright_i,
  output logic [lfgr_pkg::CHAN_W-1:0] scaled_o
);
  import lfgr_pkg::*;

  logic [2*CHAN_W-1:0] prod;
  logic [2*CHAN_W:0]   rounded;
  logic [2*CHAN_W:0]   approx;

  // Division by 255 as (x + (x >> 8) + 1) >> 8, exact for x below 65535.
  assign prod     = chan_i * bright_i;
  assign rounded  = {1'b0, prod} + (2*CHAN_W+1)'(127);
  assign approx   = rounded + (rounded >> CHAN_W) + (2*CHAN_W+1)'(1);
  assign scaled_o = approx[2*CHAN_W-1:CHAN_W];

endmodule

// ===== hdl/lfgr_emit.sv =====
`timescale 1ns / 1ps

module lfgr_emit #(
  parameter int OUTPUT_LEDS = 4,
  parameter int IDX_W = 2
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  lfgr_pkg::emit_req_t         req_i,
  input  logic [lfgr_pkg::CHAN_W-1:0] bright_i,
  output logic [IDX_W-1:0]            led_idx_o,
  output logic                        busy_o,
  output logic                        out_valid,
  input  logic                        out_stall,
  output lfgr_pkg::out_item_t         out_data
);
  import lfgr_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CALC = 3'b010,
    ST_SEND = 3'b100
  } emit_state_t;

  localparam logic [1:0] CH_G = 2'd0;
  localparam logic [1:0] CH_R = 2'd1;
  localparam logic [1:0] CH_B = 2'd2;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(OUTPUT_LEDS - 1);

  emit_state_t       state_r, state_nxt;
  logic [1:0]        chan_r, chan_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [SEL_W-1:0]  sel_r;
  logic [GRB_W-1:0]  word_r;
  logic [GRB_W-1:0]  pal_word;
  logic [CHAN_W-1:0] pal_chan;
  logic [CHAN_W-1:0] scaled;

  // Palette in GRB order; codes beyond purple fall back to red.
  always_comb begin
    case (sel_r)
      PAL_GREEN:  pal_word = 24'hff0000;
      PAL_BLUE:   pal_word = 24'h0000ff;
      PAL_YELLOW: pal_word = 24'hffff00;
      PAL_PURPLE: pal_word = 24'h0080ff;
      default:    pal_word = 24'h00ff00;
    endcase
  end

  always_comb begin
    case (chan_r)
      CH_G:    pal_chan = pal_word[23:16];
      CH_R:    pal_chan = pal_word[15:8];
      default: pal_chan = pal_word[7:0];
    endcase
  end

  lfgr_scale u_scale (
    .chan_i   (pal_chan),
    .bright_i (bright_i),
    .scaled_o (scaled)
  );

  always_comb begin
    state_nxt = state_r;
    chan_nxt  = chan_r;
    idx_nxt   = idx_r;
    unique case (state_r)
      ST_IDLE: begin
        if (req_i.go) begin
          state_nxt = ST_CALC;
          chan_nxt  = CH_G;
          idx_nxt   = '0;
        end
      end
      ST_CALC: begin
        if (chan_r == CH_B) begin
          state_nxt = ST_SEND;
        end else begin
          chan_nxt = chan_r + 2'd1;
        end
      end
      ST_SEND: begin
        if (!out_stall) begin
          if (idx_r == LAST_IDX) begin
            state_nxt = ST_IDLE;
          end else begin
            state_nxt = ST_CALC;
            chan_nxt  = CH_G;
            idx_nxt   = idx_r + IDX_W'(1);
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      chan_r  <= CH_G;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      chan_r  <= chan_nxt;
      idx_r   <= idx_nxt;
    end
  end

  // One colour channel is scaled per cycle into the held output word.
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && req_i.go) begin
      sel_r <= req_i.sel;
    end
    if (state_r == ST_CALC) begin
      case (chan_r)
        CH_G:    word_r[23:16] <= scaled;
        CH_R:    word_r[15:8]  <= scaled;
        default: word_r[7:0]   <= scaled;
      endcase
    end
  end

  assign led_idx_o        = idx_r;
  assign busy_o           = state_r != ST_IDLE;
  assign out_valid        = state_r == ST_SEND;
  assign out_data.led_grb = word_r;
  assign out_data.last    = idx_r == LAST_IDX;

  a_calc_chan: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_CALC |-> chan_r == CH_G || chan_r == CH_R || chan_r == CH_B)
    else $error("channel counter out of range");

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != ST_IDLE |-> idx_r <= LAST_IDX)
    else $error("LED index beyond the last LED");

  a_send_after_blue: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r) == ST_CALC && $past(chan_r) == CH_B)
    else $error("word offered before all channels were scaled");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_data.last |=> state_r == ST_IDLE)
    else $error("sequencer kept running after the last word");

endmodule

// ===== hdl/led_frame_group_remapper.sv =====
`timescale 1ns / 1ps

// LED frame group remapper.
// The input channel (in_valid / in_stall / in_data) carries either a pixel
// word or a frame-end event. A pixel that is taken updates the saturating
// pixel count and, at a group's centre position, that group's stored peak
// brightness. A frame end with exactly INPUT_PIXELS pixels and output
// enabled starts the LED word sequencer; the count is cleared always.
// The sequencer scales one colour channel per cycle through a single shared
// multiply and divide-by-255 unit: after each transfer the next LED word is
// built in the CALC state, green, red then blue, and is then offered on
// out_valid / out_data. A frame has OUTPUT_LEDS words; the final word
// carries last. in_stall is high while the sequencer runs. When the
// receiver stalls, the offered word holds and the sequencer waits. Reset
// clears the count, sets colour select to red and output enable to one; the
// brightness stores are not cleared. Configuration is written through
// cfg_we / cfg_index / cfg_wdata; the user must write it only while the
// block is idle, as the block itself does not enforce this.

module led_frame_group_remapper #(
  parameter int INPUT_PIXELS = 12,
  parameter int OUTPUT_LEDS  = 4,
  parameter int GROUP_SIZE   = 3,
  parameter int MAX_PIXELS   = 256
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  lfgr_pkg::in_item_t               in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output lfgr_pkg::out_item_t              out_data,
  input  logic                             cfg_we,
  input  logic [lfgr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [lfgr_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import lfgr_pkg::*;

  localparam int CNT_MAX = (MAX_PIXELS > INPUT_PIXELS) ? MAX_PIXELS : INPUT_PIXELS;
  localparam int CNT_W   = $clog2(CNT_MAX + 1);
  localparam int IDX_W   = (OUTPUT_LEDS > 1) ? $clog2(OUTPUT_LEDS) : 1;

  logic [SEL_W-1:0]  color_select_r;
  logic              output_enable_r;
  logic [CNT_W-1:0]  pixel_count_r;
  logic [CHAN_W-1:0] bright_r [OUTPUT_LEDS];
  logic              in_xfer;
  logic              pixel_ok;
  logic [CHAN_W-1:0] peak;
  logic [IDX_W-1:0]  led_idx;
  logic              busy;
  emit_req_t         req;

  function automatic logic [CHAN_W-1:0] peak_of(input logic [GRB_W-1:0] grb);
    logic [CHAN_W-1:0] m;
    m = (grb[23:16] > grb[15:8]) ? grb[23:16] : grb[15:8];
    return (m > grb[7:0]) ? m : grb[7:0];
  endfunction

  assign in_stall = busy;
  assign in_xfer  = in_valid && !in_stall;
  assign pixel_ok = in_xfer && in_data.op == OP_PIXEL &&
                    pixel_count_r < CNT_W'(MAX_PIXELS);
  assign peak     = peak_of(in_data.pixel_grb);

  assign req.go  = in_xfer && in_data.op == OP_FRAME_END && output_enable_r &&
                   pixel_count_r == CNT_W'(INPUT_PIXELS);
  assign req.sel = color_select_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      color_select_r  <= '0;
      output_enable_r <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_COLOR_SELECT:  color_select_r  <= cfg_wdata;
        REG_OUTPUT_ENABLE: output_enable_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pixel_count_r <= '0;
    end else if (in_xfer) begin
      if (in_data.op == OP_FRAME_END) begin
        pixel_count_r <= '0;
      end else if (pixel_ok) begin
        pixel_count_r <= pixel_count_r + CNT_W'(1);
      end
    end
  end

  // Each group's centre pixel sits at zero-based position 2 + g * GROUP_SIZE.
  always_ff @(posedge clk) begin
    for (int g = 0; g < OUTPUT_LEDS; g++) begin
      if (pixel_ok && 32'(pixel_count_r) == 2 + g * GROUP_SIZE) begin
        bright_r[g] <= peak;
      end
    end
  end

  lfgr_emit #(
    .OUTPUT_LEDS (OUTPUT_LEDS),
    .IDX_W       (IDX_W)
  ) u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_i     (req),
    .bright_i  (bright_r[led_idx]),
    .led_idx_o (led_idx),
    .busy_o    (busy),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  a_count_sat: assert property (@(posedge clk) disable iff (!rst_n)
    pixel_count_r <= CNT_W'(MAX_PIXELS))
    else $error("pixel count beyond saturation limit");

  a_frame_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && in_data.op == OP_FRAME_END |=> pixel_count_r == '0)
    else $error("frame end did not clear the pixel count");

  a_start_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    req.go |=> in_stall)
    else $error("input taken while the sequencer runs");

endmodule

// ===== sim/tb_led_frame_group_remapper.sv =====
`timescale 1ns / 1ps

module tb_led_frame_group_remapper;
  import lfgr_pkg::*;

  localparam int N_PIXELS    = 12;
  localparam int N_LEDS      = 4;
  localparam int GROUP_SIZE  = 3;
  localparam int PIXEL_LIMIT = 256;
  localparam int CENTRE_POS  = 2;

  // Indexes past the palette; they fall back to red.
  localparam logic [SEL_W-1:0] PAL_SPARE_LO   = 3'd5;
  localparam logic [SEL_W-1:0] PAL_SPARE_MID  = 3'd6;
  localparam logic [SEL_W-1:0] PAL_SPARE_HI   = 3'd7;

  localparam int N_PHASES         = 8;
  localparam int RANDOM_PER_PHASE = 12;
  localparam int SETTLE_CYCLES    = 24;
  localparam int LONG_HOLD        = 300;
  localparam int CYCLE_LIMIT      = 400000;

  // Per-phase settings, phase 0 in the lowest slice.
  localparam logic [N_PHASES*SEL_W-1:0] PHASE_COLOURS = {
    PAL_RED, PAL_SPARE_MID, PAL_SPARE_HI, PAL_SPARE_LO,
    PAL_PURPLE, PAL_YELLOW, PAL_BLUE, PAL_GREEN
  };
  localparam logic [N_PHASES-1:0]   PHASE_ENABLES = 8'b1111_1101;
  localparam logic [N_PHASES*8-1:0] PHASE_ODDS    = {
    8'd0, 8'd4, 8'd8, 8'd5, 8'd6, 8'd0, 8'd3, 8'd4
  };

  class frame_scoreboard;
    logic [SEL_W-1:0] colour_sel;
    logic             out_enable;
    int unsigned      pixel_tally;
    logic [7:0]       centre_peak [N_LEDS];
    out_item_t        pending_words [$];
    int               mismatches;
    int               words_seen;
    int               frame_ends;
    int               frames_lit;

    function new();
      colour_sel  = PAL_RED;
      out_enable  = 1'b1;
      pixel_tally = 0;
      foreach (centre_peak[i]) centre_peak[i] = '0;
      mismatches  = 0;
      words_seen  = 0;
      frame_ends  = 0;
      frames_lit  = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      if (idx == REG_COLOR_SELECT) colour_sel = val[SEL_W-1:0];
      else if (idx == REG_OUTPUT_ENABLE) out_enable = val[0];
    endfunction

    function logic [7:0] scaled(logic [7:0] c, logic [7:0] b);
      return 8'((int'(c) * int'(b) + 127) / 255);
    endfunction

    function void note_input(in_item_t it);
      logic [7:0]  g, r, b, pk;
      logic [23:0] base;
      out_item_t   w;
      if (it.op == OP_PIXEL) begin
        // Pixels beyond the saturation point leave everything untouched.
        if (pixel_tally < PIXEL_LIMIT) begin
          g  = it.pixel_grb[23:16];
          r  = it.pixel_grb[15:8];
          b  = it.pixel_grb[7:0];
          pk = (g > r) ? g : r;
          if (b > pk) pk = b;
          for (int k = 0; k < N_LEDS; k++)
            if (pixel_tally == CENTRE_POS + k * GROUP_SIZE) centre_peak[k] = pk;
          pixel_tally++;
        end
      end else begin
        frame_ends++;
        if (pixel_tally == N_PIXELS && out_enable) begin
          case (colour_sel)
            PAL_GREEN:  base = 24'hff0000;
            PAL_BLUE:   base = 24'h0000ff;
            PAL_YELLOW: base = 24'hffff00;
            PAL_PURPLE: base = 24'h0080ff;
            default:    base = 24'h00ff00;
          endcase
          for (int k = 0; k < N_LEDS; k++) begin
            w.led_grb = {scaled(base[23:16], centre_peak[k]),
                         scaled(base[15:8], centre_peak[k]),
                         scaled(base[7:0], centre_peak[k])};
            w.last    = (k == N_LEDS - 1);
            pending_words.push_back(w);
          end
          frames_lit++;
        end
        pixel_tally = 0;
      end
    endfunction

    function void flag(string what, out_item_t want, out_item_t got);
      mismatches++;
      if (mismatches <= 10)
        $display("%s: expected grb %06h last %0b, got grb %06h last %0b",
                 what, want.led_grb, want.last, got.led_grb, got.last);
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      words_seen++;
      if (pending_words.size() == 0) begin
        flag("LED word with nothing outstanding", '0, got);
      end else begin
        want = pending_words.pop_front();
        if (got.led_grb !== want.led_grb || got.last !== want.last)
          flag("LED word mismatch", want, got);
      end
    endfunction

    function int outstanding();
      return pending_words.size();
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_stall;
  out_item_t             out_data;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  frame_scoreboard sb = new();
  int              idle_odds     = 0;
  logic            long_hold_req = 1'b0;
  int              items_sent    = 0;
  int              cycle_count   = 0;

  led_frame_group_remapper dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("led_frame_group_remapper test failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
  end

  // Receiver: random stall bursts, plus one long hold-off on request.
  initial begin
    int stall_left;
    stall_left = 0;
    out_stall  = 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        stall_left    = LONG_HOLD;
      end else if (stall_left == 0 && idle_odds != 0 &&
                   $urandom_range(1, 4 * idle_odds) == 1) begin
        stall_left = $urandom_range(1, 18);
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  function automatic logic [GRB_W-1:0] rand_pixel();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return GRB_W'($urandom);
    endcase
  endfunction

  task automatic send_item(in_item_t it);
    if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    sb.note_input(it);
    items_sent++;
  endtask

  task automatic send_frame(int n_pixels);
    in_item_t it;
    for (int k = 0; k < n_pixels; k++) begin
      it.op        = OP_PIXEL;
      it.pixel_grb = rand_pixel();
      send_item(it);
    end
    it.op        = OP_FRAME_END;
    it.pixel_grb = GRB_W'($urandom);
    send_item(it);
  endtask

  // Lowers valid in the step of the last transfer, then waits for the
  // sequencer to drain and settle before any register write.
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_registers(logic [SEL_W-1:0] colour, logic enable);
    cfg_we    <= 1'b1;
    cfg_index <= REG_COLOR_SELECT;
    cfg_wdata <= CFG_DATA_W'(colour);
    @(posedge clk);
    sb.write_reg(REG_COLOR_SELECT, CFG_DATA_W'(colour));
    cfg_index <= REG_OUTPUT_ENABLE;
    cfg_wdata <= CFG_DATA_W'(enable);
    @(posedge clk);
    sb.write_reg(REG_OUTPUT_ENABLE, CFG_DATA_W'(enable));
    cfg_we <= 1'b0;
  endtask

  task automatic run_directed();
    logic [N_PIXELS*GRB_W-1:0] px;
    in_item_t                  it;
    // Centre pixels carry peaks of 0, 255, 128 and 1; the rest mix extremes.
    px = {24'h010000, 24'ha5a5a5, 24'h5a5a5a, 24'h7f0080,
          24'h00ff00, 24'h800000, 24'hffffff, 24'habcdef,
          24'h123456, 24'h000000, 24'hffffff, 24'h000000};
    for (int k = 0; k < N_PIXELS; k++) begin
      it.op        = OP_PIXEL;
      it.pixel_grb = px[k*GRB_W +: GRB_W];
      send_item(it);
    end
    it.op        = OP_FRAME_END;
    it.pixel_grb = '1;
    send_item(it);
    // An empty frame, then one that is a pixel short: neither emits.
    send_frame(0);
    send_frame(N_PIXELS - 1);
  endtask

  task automatic run_random(int budget);
    int start_count;
    int len;
    start_count = items_sent;
    while (items_sent - start_count < budget) begin
      case ($urandom_range(0, 9))
        0:       len = $urandom_range(0, N_PIXELS - 1);
        1:       len = $urandom_range(N_PIXELS + 1, 2 * N_PIXELS);
        default: len = N_PIXELS;
      endcase
      send_frame(len);
    end
  endtask

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_index = REG_COLOR_SELECT;
    cfg_wdata = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    idle_odds = 4;
    run_directed();
    settle();

    for (int p = 0; p < N_PHASES; p++) begin
      set_registers(PHASE_COLOURS[p*SEL_W +: SEL_W], PHASE_ENABLES[p]);
      idle_odds = int'(PHASE_ODDS[p*8 +: 8]);
      // The receiver holds off while the sender keeps offering whole frames.
      if (p == 2) begin
        long_hold_req = 1'b1;
        send_frame(N_PIXELS);
      end
      // One oversized frame drives the pixel count into saturation.
      if (p == 3) send_frame($urandom_range(PIXEL_LIMIT + 1, PIXEL_LIMIT + 6));
      run_random(RANDOM_PER_PHASE);
      settle();
    end

    $display("Run covered %0d input transfers and %0d frame ends, %0d of which emitted,",
             items_sent, sb.frame_ends, sb.frames_lit);
    $display("with %0d LED word transfers checked over %0d register settings.",
             sb.words_seen, N_PHASES + 1);
    if (sb.mismatches + sb.outstanding() == 0) begin
      $display("led_frame_group_remapper test passed");
    end else begin
      $display("led_frame_group_remapper test failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/lfgr_pkg.sv
hdl/lfgr_scale.sv
hdl/lfgr_emit.sv
hdl/led_frame_group_remapper.sv
sim/tb_led_frame_group_remapper.sv
